[hdl/bmp_pixel_blit_to_framebuffer_macros.svh]
// assertion macros shared by the blitter rtl
`ifndef BMP_PIXEL_BLIT_TO_FRAMEBUFFER_MACROS_SVH
`define BMP_PIXEL_BLIT_TO_FRAMEBUFFER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked while out of reset
`define BPB_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpb assertion failed");
// next-cycle implication, checked while out of reset
`define BPB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpb assertion failed");
`else
`define BPB_ASSERT_IMPLIES(lbl, ante, cons)
`define BPB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/bpb_pkg.sv]
// shared types and constants of the bmp pixel blitter
`default_nettype none
package bpb_pkg;

  // parameter defaults
  localparam int SCREEN_WIDTH_DEF   = 800;
  localparam int SCREEN_HEIGHT_DEF  = 480;
  localparam int MAX_IMAGE_SIDE_DEF = 4096;

  // register reset values
  localparam int RST_IMAGE_WIDTH  = 800;
  localparam int RST_IMAGE_HEIGHT = 480;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BYTE    = 3'd4;

  // field widths
  localparam int BYTE_W  = 8;
  localparam int COL_W   = 13;
  localparam int ADDR_W  = 19;
  localparam int COLOR_W = 32;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // one finished pixel on its way to the back end
  typedef struct packed {
    logic [COL_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [COLOR_W-1:0] color;
    logic               on;
    logic               last;
  } bpb_pix_t;

endpackage
`default_nettype wire

[hdl/bpb_front.sv]
// front end: config registers, byte assembly, padding skip, pixel position
`default_nettype none
`include "bmp_pixel_blit_to_framebuffer_macros.svh"
module bpb_front #(
  parameter int SCREEN_WIDTH   = bpb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT  = bpb_pkg::SCREEN_HEIGHT_DEF,
  parameter int MAX_IMAGE_SIDE = bpb_pkg::MAX_IMAGE_SIDE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bpb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  input  logic [bpb_pkg::BYTE_W-1:0]      in_pixel_byte,
  output logic                            in_stall,
  input  logic                            q_full,
  output logic                            q_push,
  output bpb_pkg::bpb_pix_t               q_push_data
);
  import bpb_pkg::*;

  localparam logic [1:0] PH_B = 2'd0;
  localparam logic [1:0] PH_G = 2'd1;
  localparam logic [1:0] PH_R = 2'd2;
  localparam logic [1:0] PH_A = 2'd3;

  // saturate an image side to 1..MAX_IMAGE_SIDE
  function automatic logic [14:0] sat_side(input logic [14:0] m);
    logic [14:0] r;
    if (m == 15'd0) begin
      r = 15'd1;
    end else if (m > 15'(MAX_IMAGE_SIDE)) begin
      r = 15'(MAX_IMAGE_SIDE);
    end else begin
      r = m;
    end
    return r;
  endfunction

  localparam logic [14:0] RST_W_EFF = sat_side(15'(RST_IMAGE_WIDTH));
  localparam logic [14:0] RST_H_EFF = sat_side(15'(RST_IMAGE_HEIGHT));

  // config state, with derived side limits kept at write time
  logic [9:0]       dest_x_r;
  logic [8:0]       dest_y_r;
  logic [COL_W-1:0] w_m1_r;
  logic [1:0]       w_lo2_r;
  logic [COL_W-1:0] h_m1_r;
  logic             bottom_up_r;
  logic             four_r;

  logic [14:0] w_eff_wr, h_mag_wr, h_eff_wr;
  logic [14:0] h_sext;

  assign w_eff_wr = sat_side({2'b00, cfg_wdata[12:0]});
  assign h_sext   = {cfg_wdata[13], cfg_wdata[13:0]};
  assign h_mag_wr = cfg_wdata[13] ? (15'd0 - h_sext) : h_sext;
  assign h_eff_wr = sat_side(h_mag_wr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_x_r    <= '0;
      dest_y_r    <= '0;
      w_m1_r      <= COL_W'(RST_W_EFF - 15'd1);
      w_lo2_r     <= RST_W_EFF[1:0];
      h_m1_r      <= COL_W'(RST_H_EFF - 15'd1);
      bottom_up_r <= 1'b1;
      four_r      <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEST_X:       dest_x_r <= cfg_wdata[9:0];
        CFG_DEST_Y:       dest_y_r <= cfg_wdata[8:0];
        CFG_IMAGE_WIDTH: begin
          w_m1_r  <= COL_W'(w_eff_wr - 15'd1);
          w_lo2_r <= w_eff_wr[1:0];
        end
        CFG_IMAGE_HEIGHT: begin
          h_m1_r      <= COL_W'(h_eff_wr - 15'd1);
          bottom_up_r <= !cfg_wdata[13] && (cfg_wdata != '0);
        end
        CFG_FOUR_BYTE:    four_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // stream state
  logic [COL_W-1:0] col_r, col_nxt;
  logic [COL_W-1:0] row_r, row_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [23:0]      partial_r, partial_nxt;
  logic [1:0]       pad_r, pad_nxt;

  logic accept, complete;
  logic col_end, row_end;
  logic [13:0]        sx;
  logic signed [14:0] sy;
  logic               on;
  logic [7:0]         alpha;
  logic [23:0]        rgb;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign complete = (phase_r == PH_A) || (phase_r == PH_R && !four_r);
  assign col_end  = col_r >= w_m1_r;
  assign row_end  = row_r >= h_m1_r;

  // screen position of the pixel being completed
  assign sx = {4'b0000, dest_x_r} + {1'b0, col_r};
  always_comb begin
    if (bottom_up_r) begin
      sy = $signed({6'b0, dest_y_r}) + $signed({2'b00, h_m1_r}) - $signed({2'b00, row_r});
    end else begin
      sy = $signed({6'b0, dest_y_r}) + $signed({2'b00, row_r});
    end
  end
  assign on = (sx < 14'(SCREEN_WIDTH)) && !sy[14] && ($unsigned(sy) < 15'(SCREEN_HEIGHT));

  // colour of the pixel being completed
  assign rgb   = (phase_r == PH_R) ? {in_pixel_byte, partial_r[15:0]} : partial_r;
  assign alpha = (phase_r == PH_A && four_r) ? in_pixel_byte : 8'h00;

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    phase_nxt   = phase_r;
    partial_nxt = partial_r;
    pad_nxt     = pad_r;
    if (accept) begin
      if (pad_r != 2'd0) begin
        pad_nxt = pad_r - 2'd1;
      end else if (phase_r == PH_B) begin
        partial_nxt[7:0] = in_pixel_byte;
        phase_nxt        = PH_G;
      end else if (phase_r == PH_G) begin
        partial_nxt[15:8] = in_pixel_byte;
        phase_nxt         = PH_R;
      end else begin
        if (phase_r == PH_R) begin
          partial_nxt[23:16] = in_pixel_byte;
        end
        if (complete) begin
          phase_nxt = PH_B;
          if (col_end) begin
            col_nxt = '0;
            pad_nxt = four_r ? 2'd0 : w_lo2_r;
            row_nxt = row_end ? '0 : row_r + COL_W'(1);
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
        end else begin
          phase_nxt = PH_A;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      phase_r   <= PH_B;
      partial_r <= '0;
      pad_r     <= '0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      phase_r   <= phase_nxt;
      partial_r <= partial_nxt;
      pad_r     <= pad_nxt;
    end
  end

  // finished pixel into the queue
  assign q_push            = accept && (pad_r == 2'd0) && complete;
  assign q_push_data.row   = on ? sy[COL_W-1:0] : '0;
  assign q_push_data.col   = on ? sx[COL_W-1:0] : '0;
  assign q_push_data.color = {alpha, rgb};
  assign q_push_data.on    = on;
  assign q_push_data.last  = col_end && row_end;

  `BPB_ASSERT_IMPLIES(a_pad_at_row_start, pad_r != 2'd0, col_r == '0)
  `BPB_ASSERT_IMPLIES(a_pad_between_pixels, pad_r != 2'd0, phase_r == PH_B)

endmodule
`default_nettype wire

[hdl/bpb_queue.sv]
// two-entry queue of finished pixels between front and back
`default_nettype none
`include "bmp_pixel_blit_to_framebuffer_macros.svh"
module bpb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bpb_pkg::bpb_pix_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output bpb_pkg::bpb_pix_t head_data
);
  import bpb_pkg::*;

  bpb_pix_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;

  // pointer step with wrap at the queue depth
  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    logic [Q_PTR_W-1:0] r;
    if (p == Q_PTR_W'(Q_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + Q_PTR_W'(1);
    end
    return r;
  endfunction

  assign full       = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_data  = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + Q_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - Q_CNT_W'(1);
      end
    end
  end

  `BPB_ASSERT_IMPLIES(a_cnt_bound, 1'b1, cnt_r <= Q_CNT_W'(Q_DEPTH))
  `BPB_ASSERT_IMPLIES(a_no_underflow, pop, cnt_r != '0)

endmodule
`default_nettype wire

[hdl/bpb_back.sv]
// back end: framebuffer address and registered result
`default_nettype none
module bpb_back #(
  parameter int SCREEN_WIDTH = bpb_pkg::SCREEN_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  input  bpb_pkg::bpb_pix_t            head_data,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bpb_pkg::ADDR_W-1:0]   out_fb_address,
  output logic [bpb_pkg::COLOR_W-1:0]  out_pixel_color,
  output logic                         out_on_screen,
  output logic                         out_last_pixel
);
  import bpb_pkg::*;

  localparam logic [COL_W-1:0] SW_C = COL_W'(SCREEN_WIDTH);

  logic                 out_valid_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [COLOR_W-1:0]   color_r;
  logic                 on_r, last_r;
  logic                 load;
  logic [2*COL_W-1:0]   prod;
  logic [2*COL_W-1:0]   addr_full;

  // row times screen width plus column
  assign prod      = {{COL_W{1'b0}}, head_data.row} * {{COL_W{1'b0}}, SW_C};
  assign addr_full = prod + {{COL_W{1'b0}}, head_data.col};

  // output register takes a new pixel when empty or when its transfer completes
  assign load = head_valid && (!out_valid_r || !out_stall);
  assign pop  = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      addr_r  <= addr_full[ADDR_W-1:0];
      color_r <= head_data.color;
      on_r    <= head_data.on;
      last_r  <= head_data.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_fb_address  = addr_r;
  assign out_pixel_color = color_r;
  assign out_on_screen   = on_r;
  assign out_last_pixel  = last_r;

endmodule
`default_nettype wire

[hdl/bmp_pixel_blit_to_framebuffer.sv]
// Top level of the BMP pixel-array blitter, bytes in, ARGB framebuffer writes out.
// Usage: raw bytes of the BMP pixel array arrive on in_pixel_byte, one per transfer
// (in_valid high, in_stall low). Each completed pixel (3 bytes for 24-bit, 4 for
// 32-bit images) yields one result transfer on out_*: framebuffer word address,
// ARGB colour, an on-screen flag (address 0 when dropped) and a last-pixel flag.
// Row padding bytes are consumed with no result.
// Throughput: one byte per cycle while the queue has room (in_stall low); the
// back end's single output register drains one pixel per cycle unless out_stall
// holds it. A pixel enters the queue with the transfer of its final byte, then
// passes through the address multiply into the output register.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 dest_x, 1 dest_y,
// 2 image_width, 3 image_height, 4 four_byte_pixels); the user writes only while idle, unchecked.
// Reset (rst_n low, synchronous): registers return to 800x480 bottom-up 32-bit
// at the screen origin, counters clear and the queue empties.
// Receiver stall: the output register holds its result; a two-entry queue
// absorbs further pixels, after which in_stall rises until room frees up.
`default_nettype none
module bmp_pixel_blit_to_framebuffer #(
  parameter int SCREEN_WIDTH   = bpb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT  = bpb_pkg::SCREEN_HEIGHT_DEF,
  parameter int MAX_IMAGE_SIDE = bpb_pkg::MAX_IMAGE_SIDE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bpb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bpb_pkg::BYTE_W-1:0]      in_pixel_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bpb_pkg::ADDR_W-1:0]      out_fb_address,
  output logic [bpb_pkg::COLOR_W-1:0]     out_pixel_color,
  output logic                            out_on_screen,
  output logic                            out_last_pixel
);
  import bpb_pkg::*;

  logic     q_push, q_full, q_pop, q_head_valid;
  bpb_pix_t q_push_data, q_head_data;

  // byte assembly and pixel classification
  bpb_front #(
    .SCREEN_WIDTH   (SCREEN_WIDTH),
    .SCREEN_HEIGHT  (SCREEN_HEIGHT),
    .MAX_IMAGE_SIDE (MAX_IMAGE_SIDE)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_pixel_byte (in_pixel_byte),
    .in_stall      (in_stall),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_push_data   (q_push_data)
  );

  // decoupling queue
  bpb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head_data)
  );

  // address generation and output register
  bpb_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_head_valid),
    .head_data       (q_head_data),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_fb_address  (out_fb_address),
    .out_pixel_color (out_pixel_color),
    .out_on_screen   (out_on_screen),
    .out_last_pixel  (out_last_pixel)
  );

endmodule
`default_nettype wire

[tb/sv/bmp_pixel_blit_to_framebuffer_tb.sv]
// self-checking testbench of the bmp pixel blitter: directed table, then random images
module bmp_pixel_blit_to_framebuffer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bpb_pkg::*;

  localparam int SCR_W       = SCREEN_WIDTH_DEF;
  localparam int SCR_H       = SCREEN_HEIGHT_DEF;
  localparam int MAX_SIDE    = MAX_IMAGE_SIDE_DEF;
  localparam int RANDOM_BYTES = 900;
  localparam int SETTLE      = 8;
  localparam int NUM_DIRECTED = 31;

  // one framebuffer write as seen on the result channel
  typedef struct packed {
    logic [ADDR_W-1:0]  fb_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               on_screen;
    logic               last_pixel;
  } pix_result_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} stim_kind_t;

  typedef struct {
    stim_kind_t            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    bit                    typed;
    pix_result_t           exp;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_DEST_X;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_pixel_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ADDR_W-1:0]     out_fb_address;
  logic [COLOR_W-1:0]    out_pixel_color;
  logic                  out_on_screen;
  logic                  out_last_pixel;

  // predicted register copy
  logic [9:0]  dest_x_r;
  logic [8:0]  dest_y_r;
  logic [12:0] img_w_r;
  logic [13:0] img_h_r;
  logic        four_byte_r;
  // predicted pixel assembly state
  logic [12:0] col_cnt;
  logic [12:0] row_cnt;
  logic [1:0]  byte_phase;
  logic [23:0] partial;
  logic [1:0]  pad_left;

  pix_result_t pending_pixels[$];
  int          mismatches = 0;
  int          send_idle_pct = 7;
  int          recv_stall_pct = 51;
  stim_row_t   directed_rows [NUM_DIRECTED];

  bmp_pixel_blit_to_framebuffer DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_byte   (in_pixel_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_fb_address  (out_fb_address),
    .out_pixel_color (out_pixel_color),
    .out_on_screen   (out_on_screen),
    .out_last_pixel  (out_last_pixel)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // one byte into the predicted blitter, gives the pixel it completes if any
  task automatic blit_byte(input logic [7:0] b, output bit produced, output pix_result_t pix);
    int         ew;
    int         hs;
    int         hm;
    int         sx;
    int         sy;
    logic [7:0] alpha;
    bit         on;
    produced = 1'b0;
    pix = '0;
    // row padding swallows the byte
    if (pad_left != 2'd0) begin
      pad_left = pad_left - 2'd1;
      return;
    end
    if (byte_phase == 2'd0) begin
      partial[7:0] = b;
      byte_phase = 2'd1;
      return;
    end
    if (byte_phase == 2'd1) begin
      partial[15:8] = b;
      byte_phase = 2'd2;
      return;
    end
    if (byte_phase == 2'd2) begin
      partial[23:16] = b;
      if (four_byte_r) begin
        byte_phase = 2'd3;
        return;
      end
      alpha = 8'h00;
    end else begin
      // a fourth byte left over after a switch to 24-bit gets alpha 0
      alpha = four_byte_r ? b : 8'h00;
    end
    byte_phase = 2'd0;
    // effective sides, zero counts as one, large ones saturate
    ew = int'(img_w_r);
    if (ew == 0) ew = 1;
    if (ew > MAX_SIDE) ew = MAX_SIDE;
    hs = $signed(img_h_r);
    hm = (hs < 0) ? -hs : hs;
    if (hm == 0) hm = 1;
    if (hm > MAX_SIDE) hm = MAX_SIDE;
    // screen position, bottom-up rows are flipped
    sx = int'(dest_x_r) + int'(col_cnt);
    if (!img_h_r[13] && img_h_r != '0) sy = int'(dest_y_r) + hm - 1 - int'(row_cnt);
    else sy = int'(dest_y_r) + int'(row_cnt);
    on = (sx < SCR_W) && (sy >= 0) && (sy < SCR_H);
    pix.fb_address  = on ? ADDR_W'(sy * SCR_W + sx) : '0;
    pix.pixel_color = {alpha, partial};
    pix.on_screen   = on;
    pix.last_pixel  = (int'(col_cnt) >= ew - 1) && (int'(row_cnt) >= hm - 1);
    produced = 1'b1;
    // advance column and row
    if (int'(col_cnt) >= ew - 1) begin
      col_cnt = '0;
      pad_left = four_byte_r ? 2'd0 : 2'(4 - ((ew * 3) & 3));
      if (int'(row_cnt) >= hm - 1) row_cnt = '0;
      else row_cnt = row_cnt + 13'd1;
    end else begin
      col_cnt = col_cnt + 13'd1;
    end
  endtask

  // wait until every predicted pixel has come out, then let the pipeline empty
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEST_X:       dest_x_r = data[9:0];
      CFG_DEST_Y:       dest_y_r = data[8:0];
      CFG_IMAGE_WIDTH:  img_w_r = data[12:0];
      CFG_IMAGE_HEIGHT: img_h_r = data[13:0];
      CFG_FOUR_BYTE:    four_byte_r = data[0];
      default: ;
    endcase
  endtask

  // one byte transfer on the input channel, with an optional idle gap first
  task automatic send_byte(input logic [7:0] b, output bit produced, output pix_result_t pix);
    int gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_pixel_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    blit_byte(b, produced, pix);
  endtask

  // receiver stalls at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // compare each result transfer with the oldest predicted pixel
  always @(posedge clk) begin : check_out
    pix_result_t want;
    pix_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_fb_address, out_pixel_color, out_on_screen, out_last_pixel};
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel addr %0d color %h on %0b last %0b", $time,
                 got.fb_address, got.pixel_color, got.on_screen, got.last_pixel);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          $display("%0t: expected addr %0d color %h on %0b last %0b", $time,
                   want.fb_address, want.pixel_color, want.on_screen, want.last_pixel);
          $display("%0t:   actual addr %0d color %h on %0b last %0b", $time,
                   got.fb_address, got.pixel_color, got.on_screen, got.last_pixel);
          mismatches++;
        end
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("bmp_pixel_blit_to_framebuffer verification failed");
    $finish;
  end

  // main stimulus
  initial begin
    bit                   has_pix;
    pix_result_t          pix;
    int                   random_sent;
    int                   nbytes;
    int                   w;
    int                   hmag;
    int                   h;
    int                   ew;
    int                   eh;
    bit                   four;
    logic [CFG_IDX_W-1:0] spare_idx;

    // reset state of the predictor
    dest_x_r = '0;
    dest_y_r = '0;
    img_w_r = 13'(RST_IMAGE_WIDTH);
    img_h_r = 14'(RST_IMAGE_HEIGHT);
    four_byte_r = 1'b1;
    col_cnt = '0;
    row_cnt = '0;
    byte_phase = '0;
    partial = '0;
    pad_left = '0;

    // reset defaults, extremes, dropped pixel, padding, mid-image change, leftover fourth byte
    directed_rows = '{
      '{ROW_BYTE, CFG_DEST_X, 14'h11, 1'b0, '0},
      '{ROW_BYTE, CFG_DEST_X, 14'h22, 1'b0, '0},
      '{ROW_BYTE, CFG_DEST_X, 14'h33, 1'b0, '0},
      '{ROW_BYTE, CFG_DEST_X, 14'h44, 1'b1, '{19'd383200, 32'h44332211, 1'b1, 1'b0}},
      '{ROW_BYTE, CFG_DEST_X, 14'hff, 1'b0, '0},
      '{ROW_BYTE, CFG_DEST_X, 14'hff, 1'b0, '0},
      '{ROW_BYTE, CFG_DEST_X, 14'hff, 1'b0, '0},
      '{ROW_BYTE, CFG_DEST_X, 14'hff, 1'b1, '{19'd383201, 32'hffffffff, 1'b1, 1'b0}},
      '{ROW_BYTE, CFG_DEST_X, 14'h00, 1'b0, '0},
      '{ROW_BYTE, CFG_DEST_X, 14'h00, 1'b0, '0},
      '{ROW_BYTE, CFG_DEST_X, 14'h00, 1'b0, '0},
      '{ROW_BYTE, CFG_DEST_X, 14'h00, 1'b1, '{19'd383202, 32'h00000000, 1'b1, 1'b0}},
      '{ROW_CFG, CFG_DEST_X, 14'd799, 1'b0, '0},
      '{ROW_CFG, CFG_DEST_Y, 14'd479, 1'b0, '0},
      '{ROW_CFG, CFG_IMAGE_WIDTH, 14'd1, 1'b0, '0},
      '{ROW_CFG, CFG_IMAGE_HEIGHT, 14'd1, 1'b0, '0},
      '{ROW_CFG, CFG_FOUR_BYTE, 14'd0, 1'b0, '0},
      '{ROW_BYTE, CFG_DEST_X, 14'h01, 1'b0, '0},
      '{ROW_BYTE, CFG_DEST_X, 14'h02, 1'b0, '0},
      '{ROW_BYTE, CFG_DEST_X, 14'h03, 1'b1, '{19'd0, 32'h00030201, 1'b0, 1'b1}},
      '{ROW_BYTE, CFG_DEST_X, 14'haa, 1'b0, '0},
      '{ROW_BYTE, CFG_DEST_X, 14'h80, 1'b0, '0},
      '{ROW_BYTE, CFG_DEST_X, 14'h7f, 1'b0, '0},
      '{ROW_BYTE, CFG_DEST_X, 14'hfe, 1'b1, '{19'd383999, 32'h00fe7f80, 1'b1, 1'b1}},
      '{ROW_BYTE, CFG_DEST_X, 14'h55, 1'b0, '0},
      '{ROW_CFG, CFG_FOUR_BYTE, 14'd1, 1'b0, '0},
      '{ROW_BYTE, CFG_DEST_X, 14'h10, 1'b0, '0},
      '{ROW_BYTE, CFG_DEST_X, 14'h20, 1'b0, '0},
      '{ROW_BYTE, CFG_DEST_X, 14'h30, 1'b0, '0},
      '{ROW_CFG, CFG_FOUR_BYTE, 14'd0, 1'b0, '0},
      '{ROW_BYTE, CFG_DEST_X, 14'h40, 1'b1, '{19'd383999, 32'h00302010, 1'b1, 1'b1}}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_byte(directed_rows[i].data[7:0], has_pix, pix);
        if (directed_rows[i].typed) pending_pixels.push_back(directed_rows[i].exp);
        else if (has_pix) pending_pixels.push_back(pix);
      end
    end

    // random phases: mostly whole small images, some noise with raw register values
    random_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) < 3) begin
        write_reg(CFG_DEST_X, CFG_DATA_W'($urandom));
        write_reg(CFG_DEST_Y, CFG_DATA_W'($urandom));
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'($urandom));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'($urandom));
        write_reg(CFG_FOUR_BYTE, CFG_DATA_W'($urandom));
        // unused register indexes are ignored
        if ($urandom_range(0, 3) == 0) begin
          spare_idx = CFG_FOUR_BYTE + CFG_IDX_W'($urandom_range(1, 3));
          write_reg(spare_idx, CFG_DATA_W'($urandom));
        end
        nbytes = $urandom_range(1, 24);
      end else begin
        w    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        hmag = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
        h    = $urandom_range(0, 1) ? -hmag : hmag;
        four = $urandom_range(0, 1);
        case ($urandom_range(0, 3))
          0:       write_reg(CFG_DEST_X, '0);
          1:       write_reg(CFG_DEST_X, CFG_DATA_W'(SCR_W - 1 - $urandom_range(0, 3)));
          2:       write_reg(CFG_DEST_X, CFG_DATA_W'($urandom_range(0, SCR_W - 1)));
          default: write_reg(CFG_DEST_X, CFG_DATA_W'($urandom_range(0, 1023)));
        endcase
        case ($urandom_range(0, 3))
          0:       write_reg(CFG_DEST_Y, '0);
          1:       write_reg(CFG_DEST_Y, CFG_DATA_W'(SCR_H - 1 - $urandom_range(0, 3)));
          2:       write_reg(CFG_DEST_Y, CFG_DATA_W'($urandom_range(0, SCR_H - 1)));
          default: write_reg(CFG_DEST_Y, CFG_DATA_W'($urandom_range(0, 511)));
        endcase
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_FOUR_BYTE, CFG_DATA_W'(four));
        ew = (w == 0) ? 1 : w;
        eh = (hmag == 0) ? 1 : hmag;
        nbytes = (four ? 4 * ew : 3 * ew + ((4 - ((3 * ew) & 3)) & 3)) * eh;
      end
      for (int k = 0; k < nbytes; k++) begin
        // idling schedule: sender light then heavy, receiver heavy then light, then none
        if (random_sent < RANDOM_BYTES / 3) begin
          send_idle_pct = 7;
          recv_stall_pct = 51;
        end else if (random_sent < 2 * RANDOM_BYTES / 3) begin
          send_idle_pct = 51;
          recv_stall_pct = 7;
        end else begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        send_byte(8'($urandom_range(0, 255)), has_pix, pix);
        if (has_pix) pending_pixels.push_back(pix);
        random_sent++;
      end
    end

    drain_results();
    if (pending_pixels.size() != 0) begin
      $display("%0t: %0d predicted pixels never arrived", $time, pending_pixels.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("bmp_pixel_blit_to_framebuffer verification clean");
    end else begin
      $display("bmp_pixel_blit_to_framebuffer verification failed");
    end
    $finish;
  end

endmodule
